/* rtl/jpct_pkg.sv */
`timescale 1ns / 1ps

package jpct_pkg;

   localparam int NUM_JOINTS_DEF = 8;

   localparam int IDX_W      = 3;
   localparam int SIG_W      = 32;
   localparam int ERR_W      = SIG_W + 1;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      LAW_PD   = 2'd0,
      LAW_PID  = 2'd1,
      LAW_CT   = 2'd2,
      LAW_HOLD = 2'd3
   } law_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONTROL_LAW  = 3'd0,
      CSR_KP_MAIN      = 3'd1,
      CSR_KP_JOINT_TWO = 3'd2,
      CSR_KP_REST      = 3'd3,
      CSR_KD_FIRST     = 3'd4,
      CSR_KD_REST      = 3'd5,
      CSR_KI_GAIN      = 3'd6,
      CSR_STEP_TIME    = 3'd7
   } csr_index_type;

   typedef struct packed {
      law_type            law;
      logic [GAIN_W-1:0]  kp_main;
      logic [GAIN_W-1:0]  kp_joint_two;
      logic [GAIN_W-1:0]  kp_rest;
      logic [GAIN_W-1:0]  kd_first;
      logic [GAIN_W-1:0]  kd_rest;
      logic [GAIN_W-1:0]  ki_gain;
      logic [GAIN_W-1:0]  step_time;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      law:          LAW_CT,
      kp_main:      16'd1600,
      kp_joint_two: 16'd1600,
      kp_rest:      16'd1600,
      kd_first:     16'd320,
      kd_rest:      16'd320,
      ki_gain:      16'd16000,
      step_time:    16'd655
   };

   typedef enum logic [1:0] {
      CMD_PD    = 2'd0,
      CMD_PID   = 2'd1,
      CMD_STORE = 2'd2,
      CMD_MAT   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic                     last_col;
      logic signed [ERR_W-1:0]  e;
      logic signed [ERR_W-1:0]  ev;
      logic [GAIN_W-1:0]        kp;
      logic [GAIN_W-1:0]        kd;
      logic signed [SIG_W-1:0]  entry;
      logic signed [SIG_W-1:0]  bias;
   } cmd_type;

   typedef enum logic [1:0] {
      B_IDLE   = 2'd0,
      B_ISSUE  = 2'd1,
      B_DRAIN  = 2'd2,
      B_FINISH = 2'd3
   } back_state_type;

endpackage

/* rtl/jpct_if.sv */
`timescale 1ns / 1ps

interface jpct_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   mode;
   logic [jpct_pkg::IDX_W-1:0]             row_index;
   logic [jpct_pkg::IDX_W-1:0]             col_index;
   logic signed [jpct_pkg::SIG_W-1:0]      position;
   logic signed [jpct_pkg::SIG_W-1:0]      velocity;
   logic signed [jpct_pkg::SIG_W-1:0]      position_ref;
   logic signed [jpct_pkg::SIG_W-1:0]      velocity_ref;
   logic signed [jpct_pkg::SIG_W-1:0]      matrix_entry;
   logic signed [jpct_pkg::SIG_W-1:0]      bias_force;

   modport source (
      output valid, mode, row_index, col_index, position, velocity,
             position_ref, velocity_ref, matrix_entry, bias_force,
      input  ready
   );

   modport sink (
      input  valid, mode, row_index, col_index, position, velocity,
             position_ref, velocity_ref, matrix_entry, bias_force,
      output ready
   );
endinterface

interface jpct_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [jpct_pkg::IDX_W-1:0]             joint_index;
   logic signed [jpct_pkg::SIG_W-1:0]      torque;
   logic                                   saturated;
   logic                                   last;

   modport source (
      output valid, joint_index, torque, saturated, last,
      input  ready
   );

   modport sink (
      input  valid, joint_index, torque, saturated, last,
      output ready
   );
endinterface

/* rtl/jpct_csr.sv */
`timescale 1ns / 1ps

module jpct_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [jpct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jpct_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output jpct_pkg::cfg_type                   cfg
);

   jpct_pkg::cfg_type cfg_ff;
   jpct_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (jpct_pkg::csr_index_type'(csr_index))
            jpct_pkg::CSR_CONTROL_LAW:  cfg_in.law = jpct_pkg::law_type'(csr_write_data[1:0]);
            jpct_pkg::CSR_KP_MAIN:      cfg_in.kp_main      = csr_write_data;
            jpct_pkg::CSR_KP_JOINT_TWO: cfg_in.kp_joint_two = csr_write_data;
            jpct_pkg::CSR_KP_REST:      cfg_in.kp_rest      = csr_write_data;
            jpct_pkg::CSR_KD_FIRST:     cfg_in.kd_first     = csr_write_data;
            jpct_pkg::CSR_KD_REST:      cfg_in.kd_rest      = csr_write_data;
            jpct_pkg::CSR_KI_GAIN:      cfg_in.ki_gain      = csr_write_data;
            jpct_pkg::CSR_STEP_TIME:    cfg_in.step_time    = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= jpct_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/jpct_front.sv */
`timescale 1ns / 1ps

module jpct_front #(
   parameter int NUM_JOINTS = jpct_pkg::NUM_JOINTS_DEF
) (
   jpct_req_if.sink                 req_chan,
   input  jpct_pkg::cfg_type        cfg,
   input  logic                     q_full,
   output logic                     q_push,
   output jpct_pkg::cmd_type        q_cmd
);

   localparam logic [4:0] JOINT_LIMIT = 5'(NUM_JOINTS);
   localparam logic [4:0] LAST_COL    = 5'(NUM_JOINTS - 1);

   logic row_ok;
   logic col_ok;
   logic keep;

   always_comb begin
      row_ok = {2'b00, req_chan.row_index} < JOINT_LIMIT;
      col_ok = {2'b00, req_chan.col_index} < JOINT_LIMIT;

      q_cmd          = '0;
      q_cmd.kind     = jpct_pkg::CMD_PD;
      q_cmd.row      = req_chan.row_index;
      q_cmd.col      = req_chan.col_index;
      q_cmd.last_col = {2'b00, req_chan.col_index} == LAST_COL;
      q_cmd.e        = {req_chan.position_ref[jpct_pkg::SIG_W-1], req_chan.position_ref}
                     - {req_chan.position[jpct_pkg::SIG_W-1], req_chan.position};
      q_cmd.ev       = {req_chan.velocity_ref[jpct_pkg::SIG_W-1], req_chan.velocity_ref}
                     - {req_chan.velocity[jpct_pkg::SIG_W-1], req_chan.velocity};
      q_cmd.entry    = req_chan.matrix_entry;
      q_cmd.bias     = req_chan.bias_force;

      // per-joint gain banks
      if (req_chan.row_index < 3'd2) begin
         q_cmd.kp = cfg.kp_main;
      end else if (req_chan.row_index == 3'd2) begin
         q_cmd.kp = cfg.kp_joint_two;
      end else begin
         q_cmd.kp = cfg.kp_rest;
      end
      q_cmd.kd = (req_chan.row_index == 3'd0) ? cfg.kd_first : cfg.kd_rest;

      keep = 1'b0;
      if (cfg.law != jpct_pkg::LAW_HOLD && row_ok) begin
         if (!req_chan.mode) begin
            keep = 1'b1;
            case (cfg.law)
               jpct_pkg::LAW_PD:  q_cmd.kind = jpct_pkg::CMD_PD;
               jpct_pkg::LAW_PID: q_cmd.kind = jpct_pkg::CMD_PID;
               default:           q_cmd.kind = jpct_pkg::CMD_STORE;
            endcase
         end else if (cfg.law == jpct_pkg::LAW_CT && col_ok) begin
            keep       = 1'b1;
            q_cmd.kind = jpct_pkg::CMD_MAT;
         end
      end

      // dropped items are still taken; they just never reach the queue
      req_chan.ready = !q_full;
      q_push         = req_chan.valid && !q_full && keep;
   end

endmodule

/* rtl/jpct_queue.sv */
`timescale 1ns / 1ps

module jpct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  jpct_pkg::cmd_type     push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output jpct_pkg::cmd_type     head_cmd
);

   localparam int PTR_W = (jpct_pkg::QUEUE_DEPTH > 1) ? $clog2(jpct_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(jpct_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(jpct_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(jpct_pkg::QUEUE_DEPTH - 1);

   jpct_pkg::cmd_type  mem_ff [jpct_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      full      = count_ff == DEPTH_CNT;
      not_empty = count_ff != '0;
      head_cmd  = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/jpct_back.sv */
`timescale 1ns / 1ps

module jpct_back #(
   parameter int NUM_JOINTS = jpct_pkg::NUM_JOINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  jpct_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  jpct_pkg::cmd_type     q_cmd,
   output logic                  q_pop,
   jpct_rsp_if.source            rsp_chan
);

   localparam int IW     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int ACC_W  = 52;   // kp*e + kd*ev + ki*integral, Q.20
   localparam int PROD_W = 64;
   localparam int MUL_W  = jpct_pkg::ERR_W;
   localparam int QW     = PROD_W - 16;  // product >> 16

   typedef enum logic [2:0] {
      OP_KP_E   = 3'd0,
      OP_KD_EV  = 3'd1,
      OP_DT_E   = 3'd2,
      OP_KI_INT = 3'd3,
      OP_MAT    = 3'd4
   } op_type;

   typedef struct packed {
      logic                 clip;
      logic signed [31:0]   val;
   } sat_type;

   localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
   localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

   function automatic sat_type sat32(input logic signed [64:0] v);
      sat_type r;
      r.clip = 1'b1;
      if (v > SAT_MAX) begin
         r.val = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r.val = 32'sh80000000;
      end else begin
         r.clip = 1'b0;
         r.val  = v[31:0];
      end
      return r;
   endfunction

   function automatic op_type op_sel(input jpct_pkg::cmd_kind_type kind,
                                     input logic [1:0] step);
      op_type op;
      case (kind)
         jpct_pkg::CMD_PID: begin
            case (step)
               2'd0:    op = OP_DT_E;
               2'd1:    op = OP_KP_E;
               2'd2:    op = OP_KD_EV;
               default: op = OP_KI_INT;
            endcase
         end
         jpct_pkg::CMD_MAT: op = OP_MAT;
         default:           op = (step == 2'd0) ? OP_KP_E : OP_KD_EV;
      endcase
      return op;
   endfunction

   jpct_pkg::back_state_type state_ff, state_in;
   logic [1:0]                step_ff, step_in;
   jpct_pkg::cmd_type         cmd_ff, cmd_in;
   logic                      pv_ff, pv_in;
   op_type                    op_ff, op_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [31:0]        int_new_ff, int_new_in;
   logic                      int_clip_ff, int_clip_in;
   logic signed [63:0]        row_acc_ff, row_acc_in;
   logic signed [31:0]        integ_ff [NUM_JOINTS];
   logic signed [31:0]        pd_ff [NUM_JOINTS];
   logic                      out_valid_ff, out_valid_in;
   logic [jpct_pkg::IDX_W-1:0] out_joint_ff, out_joint_in;
   logic signed [31:0]        out_torque_ff, out_torque_in;
   logic                      out_sat_ff, out_sat_in;

   op_type                    op_cur;
   logic [1:0]                last_step;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_full;
   logic signed [31:0]        pd_rd, int_rd;
   logic signed [QW-1:0]      prod_q;
   logic signed [QW:0]        int_sum;
   sat_type                   int_sat;
   sat_type                   t_pd;
   sat_type                   t_mat;
   logic                      emit;
   logic                      out_free;
   logic                      int_we;
   logic                      pd_we;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd_in        = cmd_ff;
      pv_in         = 1'b0;
      op_in         = op_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      int_new_in    = int_new_ff;
      int_clip_in   = int_clip_ff;
      row_acc_in    = row_acc_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_joint_in  = out_joint_ff;
      out_torque_in = out_torque_ff;
      out_sat_in    = out_sat_ff;
      q_pop         = 1'b0;
      int_we        = 1'b0;
      pd_we         = 1'b0;

      op_cur = op_sel(cmd_ff.kind, step_ff);
      case (cmd_ff.kind)
         jpct_pkg::CMD_PID: last_step = 2'd3;
         jpct_pkg::CMD_MAT: last_step = 2'd0;
         default:           last_step = 2'd1;
      endcase

      pd_rd  = pd_ff[IW'(cmd_ff.col)];
      int_rd = integ_ff[IW'(cmd_ff.row)];

      // shared multiplier operand select
      case (op_cur)
         OP_KP_E: begin
            mul_a = $signed({17'b0, cmd_ff.kp});
            mul_b = cmd_ff.e;
         end
         OP_KD_EV: begin
            mul_a = $signed({17'b0, cmd_ff.kd});
            mul_b = cmd_ff.ev;
         end
         OP_DT_E: begin
            mul_a = $signed({17'b0, cfg.step_time});
            mul_b = cmd_ff.e;
         end
         OP_KI_INT: begin
            mul_a = $signed({17'b0, cfg.ki_gain});
            mul_b = {int_new_ff[31], int_new_ff};
         end
         default: begin
            mul_a = {cmd_ff.entry[31], cmd_ff.entry};
            mul_b = {pd_rd[31], pd_rd};
         end
      endcase
      mul_full = mul_a * mul_b;

      // consume the registered product of the previous issue
      prod_q  = prod_ff[PROD_W-1:16];
      int_sum = {int_rd[31], {(QW-32){int_rd[31]}}, int_rd} + {prod_q[QW-1], prod_q};
      int_sat = sat32(65'(int_sum));
      if (pv_ff) begin
         case (op_ff)
            OP_DT_E: begin
               int_new_in  = int_sat.val;
               int_clip_in = int_sat.clip;
               int_we      = 1'b1;
            end
            OP_MAT: begin
               if (cmd_ff.col == '0) begin
                  row_acc_in = 64'(prod_q);
               end else begin
                  row_acc_in = row_acc_ff + 64'(prod_q);
               end
            end
            default: acc_in = acc_ff + prod_ff[ACC_W-1:0];
         endcase
      end

      t_pd     = sat32(65'($signed(acc_ff[ACC_W-1:4])));
      t_mat    = sat32(65'(row_acc_ff) + 65'(cmd_ff.bias));
      emit     = (cmd_ff.kind != jpct_pkg::CMD_STORE)
              && (cmd_ff.kind != jpct_pkg::CMD_MAT || cmd_ff.last_col);
      out_free = !out_valid_ff || rsp_chan.ready;

      case (state_ff)
         jpct_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               cmd_in      = q_cmd;
               step_in     = 2'd0;
               acc_in      = '0;
               int_clip_in = 1'b0;
               state_in    = jpct_pkg::B_ISSUE;
            end
         end
         jpct_pkg::B_ISSUE: begin
            pv_in   = 1'b1;
            op_in   = op_cur;
            prod_in = mul_full[PROD_W-1:0];
            if (step_ff == last_step) begin
               state_in = jpct_pkg::B_DRAIN;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         jpct_pkg::B_DRAIN: begin
            state_in = jpct_pkg::B_FINISH;
         end
         jpct_pkg::B_FINISH: begin
            if (!emit || out_free) begin
               state_in = jpct_pkg::B_IDLE;
               if (cmd_ff.kind == jpct_pkg::CMD_STORE) begin
                  pd_we = 1'b1;
               end
               if (emit) begin
                  out_valid_in = 1'b1;
                  out_joint_in = cmd_ff.row;
                  if (cmd_ff.kind == jpct_pkg::CMD_MAT) begin
                     out_torque_in = t_mat.val;
                     out_sat_in    = t_mat.clip;
                  end else begin
                     out_torque_in = t_pd.val;
                     out_sat_in    = t_pd.clip || int_clip_ff;
                  end
               end
            end
         end
         default: state_in = jpct_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jpct_pkg::B_IDLE;
         step_ff      <= '0;
         pv_ff        <= 1'b0;
         row_acc_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pv_ff        <= pv_in;
         row_acc_ff   <= row_acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      op_ff         <= op_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      int_new_ff    <= int_new_in;
      int_clip_ff   <= int_clip_in;
      out_joint_ff  <= out_joint_in;
      out_torque_ff <= out_torque_in;
      out_sat_ff    <= out_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_JOINTS; i++) begin
            integ_ff[i] <= '0;
         end
      end else if (int_we) begin
         integ_ff[IW'(cmd_ff.row)] <= int_new_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pd_we) begin
         pd_ff[IW'(cmd_ff.row)] <= t_pd.val;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.joint_index = out_joint_ff;
   assign rsp_chan.torque      = out_torque_ff;
   assign rsp_chan.saturated   = out_sat_ff;
   assign rsp_chan.last        = 1'b1;

endmodule

/* rtl/joint_pid_computed_torque_core.sv */
`timescale 1ns / 1ps
// Multi-joint torque controller: PD, PID or computed-torque law.
// req_chan carries joint samples (mode 0) and mass-matrix entries (mode 1);
// rsp_chan returns one torque per emitting item, valid/ready, last always 1.
// csr_* is a write-only port; user must write it only while idle, unchecked.
// The front stage takes an item whenever the two-entry command queue has
// room; items that produce nothing are taken and discarded at once.
// The back stage runs each command through one shared 33x33 multiplier, one
// product per cycle, registered before accumulation:
//   PD sample or stored term: kp*e, then kd*ev; PID sample: dt*e into the
//   integral, then kp*e, kd*ev and ki*integral; matrix entry: entry*PD term.
// B_DRAIN adds the last product, then B_FINISH loads the result register.
// A result sits in the output register until transferred; the back stage
// then stalls only when it needs that register again, and the queue keeps
// accepting up to two more items.
// Reset restores register defaults, zeroes the integrals and row accumulator,
// and empties queue and output register. Stored PD terms are undefined until
// written.
module joint_pid_computed_torque_core #(
   parameter int NUM_JOINTS = jpct_pkg::NUM_JOINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [jpct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jpct_pkg::CSR_DATA_W-1:0]     csr_write_data,
   jpct_req_if.sink                            req_chan,
   jpct_rsp_if.source                          rsp_chan
);

   jpct_pkg::cfg_type  cfg;
   logic               q_push;
   jpct_pkg::cmd_type  push_cmd;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   jpct_pkg::cmd_type  head_cmd;

   jpct_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   jpct_front #(
      .NUM_JOINTS (NUM_JOINTS)
   ) u_front (
      .req_chan (req_chan),
      .cfg      (cfg),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   jpct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_cmd  (head_cmd)
   );

   jpct_back #(
      .NUM_JOINTS (NUM_JOINTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_cmd    (head_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
